// ----- sv/nlp_pkg.sv -----
package nlp_pkg;

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_QOPEN  = 4'd1;
	localparam logic [3:0] PH_QCLOSE = 4'd2;
	localparam logic [3:0] PH_BIN    = 4'd3;
	localparam logic [3:0] PH_DOLLAR = 4'd4;
	localparam logic [3:0] PH_MINUS  = 4'd5;
	localparam logic [3:0] PH_NUM    = 4'd6;

	localparam logic [31:0] NEG_MASK     = 32'h0000_ffff;
	localparam logic [7:0]  LOWER_OFFSET = 8'd87;
	localparam logic [7:0]  UPPER_OFFSET = 8'd55;
	localparam logic [7:0]  LEN_MAX      = 8'd255;

	typedef struct packed {
		logic [3:0]  phase;
		logic [31:0] dec_acc;
		logic [31:0] hex_acc;
		logic        negative;
		logic        hex_mode;
		logic [7:0]  count;
		logic [7:0]  held_char;
		logic        quote_kind;
	} nlp_state_t;

	typedef struct packed {
		logic        emit;
		logic [31:0] value;
		logic        ok;
		logic [7:0]  length;
	} nlp_result_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_lower_hex(input logic [7:0] c);
		return (c >= "a") && (c <= "f");
	endfunction

	function automatic logic is_upper_hex(input logic [7:0] c);
		return (c >= "A") && (c <= "F");
	endfunction

	function automatic logic is_hexd(input logic [7:0] c);
		return is_dec(c) || is_lower_hex(c) || is_upper_hex(c);
	endfunction

	function automatic logic [7:0] bump(input logic [7:0] cnt);
		return (cnt < LEN_MAX) ? cnt + 8'd1 : cnt;
	endfunction

endpackage

// ----- sv/nlp_step.sv -----
module nlp_step (
	input  nlp_pkg::nlp_state_t  cur,
	input  logic                 start_req,
	input  logic [7:0]           ch,
	input  logic [15:0]          current_address,
	output nlp_pkg::nlp_state_t  nxt,
	output nlp_pkg::nlp_result_t res
);
	import nlp_pkg::*;

	logic [31:0] dec_mul;
	logic [31:0] dec_acc_in;
	logic [31:0] dec_digit;
	logic [31:0] dec_accum;
	logic [31:0] hex_accum;
	logic [3:0]  nib;
	logic [31:0] dec_neg;
	logic [31:0] hex_neg;
	logic [31:0] fin_value;
	logic        close_ok;

	assign dec_acc_in = start_req ? 32'd0 : cur.dec_acc;
	assign dec_mul    = (dec_acc_in << 3) + (dec_acc_in << 1);
	assign dec_digit  = {24'd0, ch - "0"};
	assign dec_accum  = dec_mul + dec_digit;

	always_comb begin
		nib = 4'd0;
		if (is_dec(ch)) begin
			nib = 4'(ch - "0");
		end else if (is_lower_hex(ch)) begin
			nib = 4'(ch - LOWER_OFFSET);
		end else if (is_upper_hex(ch)) begin
			nib = 4'(ch - UPPER_OFFSET);
		end
	end

	assign hex_accum = {cur.hex_acc[27:0], nib};
	assign dec_neg   = (cur.dec_acc ^ NEG_MASK) + 32'd1;
	assign hex_neg   = (cur.hex_acc ^ NEG_MASK) + 32'd1;
	assign close_ok  = cur.quote_kind ? (ch == "\"") : (ch == "'");

	always_comb begin
		fin_value = cur.dec_acc;
		if (cur.hex_mode) begin
			fin_value = cur.negative ? hex_neg : cur.hex_acc;
		end else if (cur.negative) begin
			fin_value = dec_neg;
		end
	end

	always_comb begin
		nxt = cur;
		res = '0;
		if (start_req) begin
			nxt.dec_acc    = 32'd0;
			nxt.hex_acc    = 32'd0;
			nxt.negative   = 1'b0;
			nxt.hex_mode   = 1'b0;
			nxt.held_char  = 8'd0;
			nxt.quote_kind = 1'b0;
			nxt.count      = 8'd1;
			priority if (ch == "'" || ch == "\"") begin
				nxt.quote_kind = (ch == "\"");
				nxt.phase      = PH_QOPEN;
			end else if (ch == "%") begin
				nxt.phase = PH_BIN;
			end else if (ch == "$") begin
				nxt.phase = PH_DOLLAR;
			end else if (ch == "-") begin
				nxt.phase = PH_MINUS;
			end else if (is_dec(ch)) begin
				nxt.dec_acc = dec_accum;
				nxt.hex_acc = {28'd0, nib};
				nxt.phase   = PH_NUM;
			end else begin
				res.emit  = 1'b1;
				nxt.phase = PH_IDLE;
			end
		end else begin
			unique case (cur.phase)
				PH_QOPEN: begin
					if (ch == 8'd0) begin
						res.emit  = 1'b1;
						nxt.phase = PH_IDLE;
					end else begin
						nxt.held_char = ch;
						nxt.count     = bump(cur.count);
						nxt.phase     = PH_QCLOSE;
					end
				end
				PH_QCLOSE: begin
					res.emit  = 1'b1;
					nxt.phase = PH_IDLE;
					if (close_ok) begin
						res.value  = {24'd0, cur.held_char};
						res.ok     = 1'b1;
						res.length = 8'd3;
					end
				end
				PH_BIN: begin
					if (ch == "0" || ch == "1") begin
						nxt.dec_acc = {cur.dec_acc[30:0], ch[0]};
						nxt.count   = bump(cur.count);
					end else if (ch == "_") begin
						nxt.count = bump(cur.count);
					end else begin
						res.emit   = 1'b1;
						res.value  = cur.dec_acc;
						res.ok     = 1'b1;
						res.length = cur.count;
						nxt.phase  = PH_IDLE;
					end
				end
				PH_DOLLAR: begin
					if (is_hexd(ch)) begin
						nxt.hex_mode = 1'b1;
						if (is_dec(ch)) begin
							nxt.dec_acc = dec_accum;
						end
						nxt.hex_acc = hex_accum;
						nxt.count   = bump(cur.count);
						nxt.phase   = PH_NUM;
					end else begin
						res.emit   = 1'b1;
						res.value  = {16'd0, current_address};
						res.ok     = 1'b1;
						res.length = 8'd1;
						nxt.phase  = PH_IDLE;
					end
				end
				PH_MINUS: begin
					if (is_dec(ch)) begin
						nxt.negative = 1'b1;
						nxt.dec_acc  = dec_accum;
						nxt.hex_acc  = hex_accum;
						nxt.count    = bump(cur.count);
						nxt.phase    = PH_NUM;
					end else begin
						res.emit  = 1'b1;
						nxt.phase = PH_IDLE;
					end
				end
				PH_NUM: begin
					if (is_hexd(ch)) begin
						if (is_dec(ch)) begin
							nxt.dec_acc = dec_accum;
						end
						nxt.hex_acc = hex_accum;
						nxt.count   = bump(cur.count);
					end else begin
						res.emit   = 1'b1;
						res.ok     = 1'b1;
						res.value  = fin_value;
						res.length = cur.count;
						nxt.phase  = PH_IDLE;
						if (ch == "h" || ch == "H") begin
							res.value  = cur.negative ? hex_neg : cur.hex_acc;
							res.length = bump(cur.count);
							nxt.hex_mode = 1'b1;
							nxt.count    = bump(cur.count);
						end
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/numeric_literal_parser.sv -----
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    start_req, ch
// out      output     out_valid/out_ready  value, ok, length
// cfg      input      cfg_wr_en            cfg_wr_data (current address)
//
// One character per cycle while the result is not stalled; a result passes through the
// input register and then the result register after its character is taken.
// arst_n clears the parser to idle and the current address to zero.
// A stalled result holds back the character waiting in the input register;
// in_ready stays high while that register is free or drains this cycle.
module numeric_literal_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        start_req,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic        ok,
	output logic [7:0]  length,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import nlp_pkg::*;

	logic        valid_s1;
	logic        start_s1;
	logic [7:0]  ch_s1;
	logic [15:0] cur_addr_q;
	nlp_state_t  state_q;
	nlp_state_t  state_nxt;
	nlp_result_t res;
	logic        out_valid_q;
	logic [31:0] value_q;
	logic        ok_q;
	logic [7:0]  length_q;
	logic        advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	nlp_step u_step (
		.cur             (state_q),
		.start_req       (start_s1),
		.ch              (ch_s1),
		.current_address (cur_addr_q),
		.nxt             (state_nxt),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q <= 16'd0;
		end else if (cfg_wr_en) begin
			cur_addr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			start_s1 <= start_req;
			ch_s1    <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			value_q  <= res.value;
			ok_q     <= res.ok;
			length_q <= res.length;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign ok        = ok_q;
	assign length    = length_q;

endmodule

// ----- sv/nlp_checker.sv -----
module nlp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic        ok,
	input logic [7:0]  length
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(ok)
			&& $stable(length))
		else $error("result word changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> value == 32'd0 && length == 8'd0)
		else $error("failed literal carries value or length");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> length != 8'd0)
		else $error("good literal with zero length");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok && length == 8'd1 |-> value[31:16] == 16'd0)
		else $error("one-character literal too large");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value),
	.ok        (ok),
	.length    (length)
);
